/* hw/rtl/fmbq_pkg.sv */
// shared types and constants for the front/middle/back queue
package fmbq_pkg;

    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_MIDDLE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_MIDDLE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP_BACK    = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // value returned by a pop on an empty queue
    localparam logic signed [DATA_W-1:0] POP_EMPTY_VALUE = -32'sd1;

    typedef logic signed [DATA_W-1:0] data_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_op_t;

endpackage

/* hw/rtl/front_middle_back_queue.sv */
// front/middle/back queue: top level with command decode, cell chain and output register
// result: registered, valid in the cycle after its command word is accepted
// throughput: one command per cycle while in_stall is low; every cell shifts in parallel from a
// broadcast position, and the read of the removed word is an or-tree across the cells
// reset: asynchronous active-low rst_n empties the queue and clears the output valid;
// stored words are undefined until written
module front_middle_back_queue #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fmbq_pkg::CMD_W-1:0]          cmd,
    input  logic signed [fmbq_pkg::DATA_W-1:0]  push_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [fmbq_pkg::DATA_W-1:0]  pop_value,
    output logic [fmbq_pkg::STATUS_W-1:0]       status,
    output logic [fmbq_pkg::OCC_W-1:0]          occupancy
);
    import fmbq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                 out_valid_reg;
    data_t                pop_value_reg;
    data_t                pop_value_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [OCC_W-1:0]     occupancy_reg;

    logic          accept;
    logic          is_push;
    logic          is_pop;
    logic          empty;
    logic          full;
    logic [CW-1:0] pos;
    cell_op_t      op;
    data_t         read_value;

    data_t cell_value [DEPTH];
    data_t cell_sel   [DEPTH];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_COUNT);

    // command decode and position select
    always_comb
    begin
        is_push = 1'b0;
        is_pop  = 1'b0;
        pos     = '0;
        unique case (cmd)
            CMD_PUSH_FRONT:
            begin
                is_push = 1'b1;
            end
            CMD_PUSH_MIDDLE:
            begin
                is_push = 1'b1;
                pos     = count_reg >> 1;
            end
            CMD_PUSH_BACK:
            begin
                is_push = 1'b1;
                pos     = count_reg;
            end
            CMD_POP_FRONT:
            begin
                is_pop = 1'b1;
            end
            CMD_POP_MIDDLE:
            begin
                is_pop = 1'b1;
                pos    = (count_reg - CW'(1)) >> 1;
            end
            CMD_POP_BACK:
            begin
                is_pop = 1'b1;
                pos    = count_reg - CW'(1);
            end
            default:
            begin
                is_push = 1'b0;
                is_pop  = 1'b0;
            end
        endcase
    end

    assign op.insert = accept && is_push && !full;
    assign op.remove = accept && is_pop && !empty;

    // chain of cells, index 0 is the front
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        data_t left_value;
        data_t right_value;

        if (i == 0)
        begin : g_first
            assign left_value = push_value;
        end
        else
        begin : g_inner_left
            assign left_value = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[i+1];
        end

        fmbq_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk         (clk),
            .op          (op),
            .pos         (pos),
            .new_value   (push_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .sel_value   (cell_sel[i])
        );
    end

    // or-tree read of the word at pos
    always_comb
    begin
        read_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            read_value = read_value | cell_sel[i];
        end
    end

    // result and next count
    always_comb
    begin
        count_next     = count_reg;
        pop_value_next = '0;
        status_next    = ST_OK;
        if (is_push)
        begin
            if (full)
                status_next = ST_FULL;
            else
                count_next = count_reg + CW'(1);
        end
        else if (is_pop)
        begin
            if (empty)
            begin
                pop_value_next = POP_EMPTY_VALUE;
                status_next    = ST_EMPTY;
            end
            else
            begin
                pop_value_next = read_value;
                count_next     = count_reg - CW'(1);
            end
        end
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_value_reg <= pop_value_next;
            status_reg    <= status_next;
            occupancy_reg <= OCC_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

    // count never runs past the cell chain
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds depth");

    // a pop on an empty queue reports empty with -1
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_pop && empty |=> out_valid && status == ST_EMPTY
            && pop_value == POP_EMPTY_VALUE)
        else $error("empty pop not reported");

    // an insert grows the queue by exactly one word
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        op.insert |=> count_reg == CW'($past(count_reg) + CW'(1)))
        else $error("insert did not advance count");

    // a removal shrinks the queue by exactly one word
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        op.remove |=> count_reg == CW'($past(count_reg) - CW'(1)))
        else $error("remove did not reduce count");

endmodule

/* hw/rtl/fmbq_cell.sv */
// one storage cell of the queue chain: shifts toward or away from the front
module fmbq_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic               clk,
    input  fmbq_pkg::cell_op_t op,
    input  logic [CW-1:0]      pos,
    input  fmbq_pkg::data_t    new_value,
    input  fmbq_pkg::data_t    left_value,
    input  fmbq_pkg::data_t    right_value,
    output fmbq_pkg::data_t    value,
    output fmbq_pkg::data_t    sel_value
);
    import fmbq_pkg::*;

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    data_t value_reg;
    data_t value_next;

    // insert shifts cells at or behind pos one place back, remove pulls them forward
    always_comb
    begin
        value_next = value_reg;
        if (op.insert)
        begin
            if (IDX > pos)
                value_next = left_value;
            else if (IDX == pos)
                value_next = new_value;
        end
        else if (op.remove)
        begin
            if (IDX >= pos)
                value_next = right_value;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    // contributes to the or-tree read of the addressed word
    assign sel_value = (IDX == pos) ? value_reg : '0;

endmodule

/* verif/tb.sv */
// self-checking testbench for the front/middle/back queue
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmbq_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int DEPTH        = 16;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_LIMIT   = 1000;
    localparam int PHASE_WORDS  = 342;
    localparam int DRAIN_CYCLES = 5;

    // command codes the block decodes as no operation
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef enum int {
        PH_RECV_SLOW,
        PH_SEND_SLOW,
        PH_FULL_RATE
    } traffic_phase_t;

    typedef struct {
        logic [CMD_W-1:0] op;
        data_t            value;
    } queue_cmd_t;

    typedef struct {
        data_t               pop_value;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } queue_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd = '0;
    data_t               push_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    data_t               pop_value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;

    traffic_phase_t phase = PH_RECV_SLOW;
    queue_cmd_t     pending_words[$];
    queue_result_t  expected_results[$];
    data_t          held_values[$];
    queue_cmd_t     next_word;
    queue_result_t  want;
    int             errors = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;
    int             quiet_cycles = 0;

    front_middle_back_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .push_value(push_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pop_value (pop_value),
        .status    (status),
        .occupancy (occupancy)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // queue behavior: apply one command to the local copy and return the result word
    function automatic queue_result_t apply_command(input logic [CMD_W-1:0] op,
                                                    input data_t value);
        queue_result_t r;
        int n;
        n = held_values.size();
        r.pop_value = '0;
        r.status = ST_OK;
        case (op) inside
            CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK:
            begin
                if (n >= DEPTH)
                    r.status = ST_FULL;
                else if (op == CMD_PUSH_FRONT)
                    held_values.push_front(value);
                else if (op == CMD_PUSH_MIDDLE)
                    held_values.insert(n / 2, value);
                else
                    held_values.push_back(value);
            end
            CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK:
            begin
                if (n == 0)
                begin
                    r.pop_value = POP_EMPTY_VALUE;
                    r.status = ST_EMPTY;
                end
                else if (op == CMD_POP_FRONT)
                    r.pop_value = held_values.pop_front();
                else if (op == CMD_POP_MIDDLE)
                begin
                    r.pop_value = held_values[(n - 1) / 2];
                    held_values.delete((n - 1) / 2);
                end
                else
                    r.pop_value = held_values.pop_back();
            end
            default:
            begin
            end
        endcase
        r.occupancy = OCC_W'(held_values.size());
        return r;
    endfunction

    function automatic int send_idle_pct(input traffic_phase_t p);
        return (p == PH_RECV_SLOW) ? 8 : (p == PH_SEND_SLOW) ? 57 : 0;
    endfunction

    function automatic int recv_stall_pct(input traffic_phase_t p);
        return (p == PH_RECV_SLOW) ? 57 : (p == PH_SEND_SLOW) ? 8 : 0;
    endfunction

    // mostly random words, with the corner values now and then
    function automatic data_t pick_value();
        case ($urandom_range(0, 15))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return data_t'($urandom());
        endcase
    endfunction

    task automatic add_word(input logic [CMD_W-1:0] op, input data_t value);
        queue_cmd_t w;
        w.op = op;
        w.value = value;
        pending_words.push_back(w);
    endtask

    // runs that lean toward filling or draining, so the fill level sweeps empty to full
    task automatic add_random(input int count);
        int left;
        int run_len;
        int push_pct;
        int roll;
        logic [CMD_W-1:0] op;
        left = count;
        while (left > 0)
        begin
            run_len = $urandom_range(4, 24);
            push_pct = ($urandom_range(0, 1) == 1) ? 80 : 25;
            for (int k = 0; k < run_len && left > 0; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    op = ($urandom_range(0, 1) == 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
                else if ($urandom_range(0, 99) < push_pct)
                    case ($urandom_range(0, 2))
                        0: op = CMD_PUSH_FRONT;
                        1: op = CMD_PUSH_MIDDLE;
                        default: op = CMD_PUSH_BACK;
                    endcase
                else
                    case ($urandom_range(0, 2))
                        0: op = CMD_POP_FRONT;
                        1: op = CMD_POP_MIDDLE;
                        default: op = CMD_POP_BACK;
                    endcase
                add_word(op, pick_value());
                left--;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // driver: offer the next pending word, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= '0;
            push_value <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(apply_command(cmd, push_value));
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(phase))
                begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    cmd <= next_word.op;
                    push_value <= next_word.value;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each accepted result word, drive the receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: %s %0d %0d %0d",
                             $time, "pop_value status occupancy",
                             pop_value, status, occupancy);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (pop_value !== want.pop_value)
                    begin
                        $display("%0t: pop_value expected %0d actual %0d",
                                 $time, want.pop_value, pop_value);
                        errors++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        errors++;
                    end
                    if (occupancy !== want.occupancy)
                    begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occupancy, occupancy);
                        errors++;
                    end
                end
            end
            // long hold-off at the start of the full-rate phase stalls the input behind the held result
            if (phase == PH_FULL_RATE && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct(phase));
        end
    end

    // watchdog on cycles with no word accepted on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // empty pops and the spare codes
        add_word(CMD_POP_FRONT, 32'sh1234_5678);
        add_word(CMD_POP_MIDDLE, '0);
        add_word(CMD_POP_BACK, -32'sd1);
        add_word(CMD_SPARE_LO, 32'sh7fff_ffff);
        add_word(CMD_SPARE_HI, 32'sh8000_0000);
        // fill to capacity through every push, odd and even middle inserts
        add_word(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        add_word(CMD_PUSH_BACK, 32'sh8000_0000);
        add_word(CMD_PUSH_MIDDLE, '0);
        add_word(CMD_PUSH_MIDDLE, -32'sd1);
        for (int k = 0; k < 12; k++)
            case (k % 3)
                0: add_word(CMD_PUSH_MIDDLE, data_t'(32'h5555_5555 ^ k));
                1: add_word(CMD_PUSH_FRONT, data_t'(32'haaaa_aaaa + k));
                default: add_word(CMD_PUSH_BACK, data_t'(k));
            endcase
        // pushes on a full queue are dropped
        add_word(CMD_PUSH_BACK, 32'sh0bad_0bad);
        add_word(CMD_PUSH_MIDDLE, 32'sh0bad_0bad);
        add_word(CMD_POP_MIDDLE, '0);
        add_word(CMD_POP_FRONT, '0);
        add_word(CMD_POP_BACK, '0);
        wait_idle();

        add_random(PHASE_WORDS);
        wait_idle();
        phase = PH_SEND_SLOW;
        add_random(PHASE_WORDS);
        wait_idle();
        add_random(PHASE_WORDS);
        phase = PH_FULL_RATE;
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* front_middle_back_queue.f */
hw/rtl/fmbq_pkg.sv
hw/rtl/fmbq_cell.sv
hw/rtl/front_middle_back_queue.sv
verif/tb.sv
